[hdl/vector_distance_metric_unit_defines.svh]
// assertion helpers shared by the vector distance metric unit
// each expects clk and rst to be visible in the module that uses it
`ifndef VECTOR_DISTANCE_METRIC_UNIT_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_UNIT_DEFINES_SVH

// same-cycle implication
`define VDM_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define VDM_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hdl/vdm_pkg.sv]
package vdm_pkg;

  // element and accumulator widths
  localparam int ELEM_W   = 8;
  localparam int DTERM_W  = 2 * ELEM_W + 1;
  localparam int PTERM_W  = 2 * ELEM_W;
  localparam int NTERM_W  = 2 * ELEM_W - 1;
  localparam int DIFF_W   = 29;
  localparam int DOT_W    = 28;
  localparam int NORM_W   = 27;
  localparam int PROD_W   = 2 * NORM_W;
  localparam int NPROD_W  = 53;

  // stream word widths
  localparam int S_DATA_W = 2 * ELEM_W;
  localparam int M_BITS   = DIFF_W + DOT_W + NPROD_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

  // defaults for the top-level parameters
  localparam int VDM_MAX_LEN     = 4096;
  localparam int VDM_QUEUE_DEPTH = 4;

  // one classified element pair, ready to accumulate
  typedef struct packed {
    logic [DTERM_W-1:0]        diff_term;
    logic signed [PTERM_W-1:0] dot_term;
    logic [NTERM_W-1:0]        na_term;
    logic [NTERM_W-1:0]        nb_term;
    logic                      last;
  } vdm_term_t;

endpackage

[hdl/vdm_front.sv]
module vdm_front (
  input  logic                         metric_mode,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [vdm_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  input  logic                         q_full,
  output logic                         push,
  output vdm_pkg::vdm_term_t           push_item
);
  import vdm_pkg::*;

  logic signed [ELEM_W-1:0]     a;
  logic signed [ELEM_W-1:0]     b;
  logic signed [ELEM_W:0]       d;
  logic signed [ELEM_W:0]       d_abs;
  logic signed [2*ELEM_W+1:0]   d_sq;
  logic signed [PTERM_W-1:0]    p_ab;
  logic signed [PTERM_W-1:0]    p_aa;
  logic signed [PTERM_W-1:0]    p_bb;

  // split the word into the two elements
  assign a = s_tdata[ELEM_W-1:0];
  assign b = s_tdata[2*ELEM_W-1:ELEM_W];

  // per-pair terms
  assign d     = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
  assign d_abs = d[ELEM_W] ? -d : d;
  assign d_sq  = d * d;
  assign p_ab  = a * b;
  assign p_aa  = a * a;
  assign p_bb  = b * b;

  // accept whenever the queue has room
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // classify by metric mode at acceptance
  always_comb begin
    if (metric_mode) begin
      push_item.diff_term = DTERM_W'(d_abs[ELEM_W-1:0]);
    end else begin
      push_item.diff_term = d_sq[DTERM_W-1:0];
    end
    push_item.dot_term = p_ab;
    push_item.na_term  = p_aa[NTERM_W-1:0];
    push_item.nb_term  = p_bb[NTERM_W-1:0];
    push_item.last     = s_tlast;
  end

endmodule

[hdl/vdm_queue.sv]
module vdm_queue #(
  parameter int DEPTH = vdm_pkg::VDM_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vdm_pkg::vdm_term_t push_item,
  output logic               full,
  output logic               q_valid,
  output vdm_pkg::vdm_term_t q_item,
  input  logic               pop
);
  import vdm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vdm_term_t       slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/vdm_back.sv]
`include "vector_distance_metric_unit_defines.svh"

module vdm_back #(
  parameter int MAX_LEN = vdm_pkg::VDM_MAX_LEN
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  vdm_pkg::vdm_term_t           q_item,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [vdm_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tuser
);
  import vdm_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  // running sums
  logic [DIFF_W-1:0]        diff_sum;
  logic signed [DOT_W-1:0]  dot_sum;
  logic [NORM_W-1:0]        na_sum;
  logic [NORM_W-1:0]        nb_sum;
  logic [CNT_W-1:0]         count;
  logic                     overflow_seen;

  logic [DIFF_W-1:0]        diff_sum_next;
  logic signed [DOT_W-1:0]  dot_sum_next;
  logic [NORM_W-1:0]        na_sum_next;
  logic [NORM_W-1:0]        nb_sum_next;
  logic [CNT_W-1:0]         count_next;
  logic                     overflow_next;

  logic [DIFF_W:0]          diff_wide;
  logic signed [DOT_W:0]    dot_wide;
  logic [NORM_W:0]          na_wide;
  logic [NORM_W:0]          nb_wide;

  // finished sums waiting for the multiplier
  logic                     fin_valid;
  logic [DIFF_W-1:0]        fin_diff;
  logic [DOT_W-1:0]         fin_dot;
  logic [NORM_W-1:0]        fin_na;
  logic [NORM_W-1:0]        fin_nb;
  logic                     fin_too_long;
  logic                     fin_ready;

  // output register
  logic                     out_valid;
  logic [DIFF_W-1:0]        out_diff;
  logic [DOT_W-1:0]         out_dot;
  logic [PROD_W-1:0]        out_prod;
  logic                     out_too_long;
  logic                     out_ready;
  logic [NPROD_W-1:0]       norm_sat;

  assign out_ready = !out_valid || m_tready;
  assign fin_ready = !fin_valid || out_ready;

  // a closing pair needs room in the finish stage
  assign pop = q_valid && (!q_item.last || fin_ready);

  // saturating accumulation of one pair
  always_comb begin
    diff_wide = {1'b0, diff_sum} + (DIFF_W + 1)'(q_item.diff_term);
    diff_sum_next = diff_wide[DIFF_W] ? '1 : diff_wide[DIFF_W-1:0];

    dot_wide = {dot_sum[DOT_W-1], dot_sum}
             + {{(DOT_W + 1 - PTERM_W){q_item.dot_term[PTERM_W-1]}}, q_item.dot_term};
    if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
      dot_sum_next = dot_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                     : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_sum_next = dot_wide[DOT_W-1:0];
    end

    na_wide = {1'b0, na_sum} + (NORM_W + 1)'(q_item.na_term);
    na_sum_next = na_wide[NORM_W] ? '1 : na_wide[NORM_W-1:0];
    nb_wide = {1'b0, nb_sum} + (NORM_W + 1)'(q_item.nb_term);
    nb_sum_next = nb_wide[NORM_W] ? '1 : nb_wide[NORM_W-1:0];

    // length check, count saturates at the limit
    if (count == CNT_W'(MAX_LEN)) begin
      count_next    = count;
      overflow_next = 1'b1;
    end else begin
      count_next    = count + 1'b1;
      overflow_next = overflow_seen;
    end
  end

  // accumulator update, cleared after a closing pair
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_sum      <= '0;
      dot_sum       <= '0;
      na_sum        <= '0;
      nb_sum        <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      if (q_item.last) begin
        diff_sum      <= '0;
        dot_sum       <= '0;
        na_sum        <= '0;
        nb_sum        <= '0;
        count         <= '0;
        overflow_seen <= 1'b0;
      end else begin
        diff_sum      <= diff_sum_next;
        dot_sum       <= dot_sum_next;
        na_sum        <= na_sum_next;
        nb_sum        <= nb_sum_next;
        count         <= count_next;
        overflow_seen <= overflow_next;
      end
    end
  end

  // finish stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= pop && q_item.last;
    end
  end

  // finish stage payload
  always_ff @(posedge clk) begin
    if (fin_ready && pop && q_item.last) begin
      fin_diff     <= diff_sum_next;
      fin_dot      <= dot_sum_next;
      fin_na       <= na_sum_next;
      fin_nb       <= nb_sum_next;
      fin_too_long <= overflow_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fin_valid;
    end
  end

  // norm product and output payload
  always_ff @(posedge clk) begin
    if (out_ready && fin_valid) begin
      out_diff     <= fin_diff;
      out_dot      <= fin_dot;
      out_prod     <= fin_na * fin_nb;
      out_too_long <= fin_too_long;
    end
  end

  // clamp the product to the result width
  assign norm_sat = (|out_prod[PROD_W-1:NPROD_W]) ? '1 : out_prod[NPROD_W-1:0];

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'({norm_sat, out_dot, out_diff});
  assign m_tuser  = out_too_long;

  `VDM_ASSERT_NXT(a_clear_after_last, pop && q_item.last, (diff_sum == '0) && (count == '0) && !overflow_seen, "sums not cleared after closing pair")
  `VDM_ASSERT_IMP(a_overflow_at_limit, overflow_seen, count == CNT_W'(MAX_LEN), "overflow flagged below the length limit")
  `VDM_ASSERT_IMP(a_out_from_fin, $rose(out_valid), $past(fin_valid), "result appeared without finished sums")

endmodule

[hdl/vector_distance_metric_unit.sv]
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: elem_a, elem_b; s_tlast: last
// m        out  m_tvalid/m_tready  m_tdata: distance, dot_product, norm_product
//                                  m_tuser: too_long
// cfg      in   cfg_wr_en          cfg_wr_data: metric_mode
//
// one element pair is taken per cycle while the term queue has room
// a result leaves after its closing pair passes queue read and
// accumulate, finish stage, then the norm multiplier into the output register
// rst is synchronous and clears the sums, the queue and metric_mode
// a stalled output holds the result; pairs keep flowing until the queue fills
// behind a closing pair that cannot enter the finish stage
module vector_distance_metric_unit #(
  parameter int MAX_LEN     = vdm_pkg::VDM_MAX_LEN,
  parameter int QUEUE_DEPTH = vdm_pkg::VDM_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,  // metric_mode
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [vdm_pkg::S_DATA_W-1:0] s_tdata,      // elem_a, elem_b
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [vdm_pkg::M_DATA_W-1:0] m_tdata,      // distance, dot_product, norm_product
  output logic                         m_tuser       // too_long
);
  import vdm_pkg::*;

  logic      metric_mode;
  logic      q_full;
  logic      push;
  vdm_term_t push_item;
  logic      q_valid;
  vdm_term_t q_item;
  logic      pop;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      metric_mode <= cfg_wr_data;
    end
  end

  vdm_front u_front (
    .metric_mode (metric_mode),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  vdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  vdm_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
